// ===== hw/rtl/sorted_color_histogram_core_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted color histogram assertion macros
// Shared concurrent check wrappers; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef SORTED_COLOR_HISTOGRAM_CORE_MACROS_SVH
`define SORTED_COLOR_HISTOGRAM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold on every clock edge outside reset.
`define SCH_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCH_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define SCH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/schist_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted color histogram package
// Sizes, action codes, cell control types and the color mask function.
// ----------------------------------------------------------------------------
package schist_pkg;

  localparam int TableDepth = 64;
  localparam int IdxWidth   = $clog2(TableDepth);
  localparam int UsedWidth  = IdxWidth + 1;
  localparam int MaxBytes   = 8;
  localparam int ColorWidth = 64;
  localparam int CountWidth = 32;
  localparam int OccWidth   = 32;
  localparam int BppWidth   = 4;

  localparam logic [BppWidth-1:0]   BppReset = 4'd3;
  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ACT_COUNT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // broadcast to every cell for one transaction
  typedef struct packed {
    logic count_en;   // count action: matching cell bumps its count
    logic insert_en;  // count action with no match and room left
  } cell_ctrl_t;

  // gathered from the row of cells
  typedef struct packed {
    logic                  any_eq;
    logic [CountWidth-1:0] match_count;
    logic [ColorWidth-1:0] rd_key;
    logic [CountWidth-1:0] rd_count;
  } chain_res_t;

  // Low 8*n bits kept, n clamped to 1..MaxBytes.
  function automatic logic [ColorWidth-1:0] color_mask(input logic [BppWidth-1:0] bpp);
    logic [BppWidth-1:0]   n;
    logic [ColorWidth-1:0] m;
    n = bpp;
    if (n == '0) n = BppWidth'(1);
    if (n > BppWidth'(MaxBytes)) n = BppWidth'(MaxBytes);
    m = '0;
    for (int b = 0; b < ColorWidth / 8; b++) begin
      if (BppWidth'(b) < n) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/schist_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted color histogram cell
// Holds one color and its count; compares against the broadcast color and
// takes its left neighbor's contents when an insert lands left of it, or loads
// the broadcast color when the insert lands at it.
module schist_cell
  import schist_pkg::*;
(
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [ColorWidth-1:0] color,
  input  logic                  in_use,
  input  logic                  prev_lt,
  input  logic [ColorWidth-1:0] prev_key,
  input  logic [CountWidth-1:0] prev_count,
  output logic [ColorWidth-1:0] key,
  output logic [CountWidth-1:0] count,
  output logic                  lt,
  output logic                  eq
);

  logic [ColorWidth-1:0] key_r,   key_nxt;
  logic [CountWidth-1:0] count_r, count_nxt;

  assign lt = in_use && (key_r < color);
  assign eq = in_use && (key_r == color);

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    if (ctrl.count_en && eq && (count_r != CountMax)) begin
      count_nxt = count_r + CountWidth'(1);
    end
    if (ctrl.insert_en) begin
      // lt is a prefix of the row: right of the insert point shift, at it load
      if (!prev_lt) begin
        key_nxt   = prev_key;
        count_nxt = prev_count;
      end else if (!lt) begin
        key_nxt   = color;
        count_nxt = CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
  end

  assign key   = key_r;
  assign count = count_r;

endmodule

// ===== hw/rtl/schist_chain.sv =====
// ----------------------------------------------------------------------------
// Sorted color histogram cell row
// Links the cells left to right and gathers match and read data.
// ----------------------------------------------------------------------------
module schist_chain
  import schist_pkg::*;
(
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [ColorWidth-1:0] color,
  input  logic [UsedWidth-1:0]  used,
  input  logic [IdxWidth-1:0]   rd_idx,
  output chain_res_t            res
);

  logic [ColorWidth-1:0] key_w   [TableDepth];
  logic [CountWidth-1:0] count_w [TableDepth];
  logic                  lt_w    [TableDepth];
  logic                  eq_w    [TableDepth];

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    localparam logic [UsedWidth-1:0] CellIdx = UsedWidth'(i);
    logic                  prev_lt;
    logic [ColorWidth-1:0] prev_key;
    logic [CountWidth-1:0] prev_count;

    if (i == 0) begin : g_head
      assign prev_lt    = 1'b1;
      assign prev_key   = '0;
      assign prev_count = '0;
    end else begin : g_link
      assign prev_lt    = lt_w[i-1];
      assign prev_key   = key_w[i-1];
      assign prev_count = count_w[i-1];
    end

    schist_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .color      (color),
      .in_use     (CellIdx < used),
      .prev_lt    (prev_lt),
      .prev_key   (prev_key),
      .prev_count (prev_count),
      .key        (key_w[i]),
      .count      (count_w[i]),
      .lt         (lt_w[i]),
      .eq         (eq_w[i])
    );
  end

  // at most one cell matches and one is addressed, so OR-gathering works
  always_comb begin
    res = '0;
    for (int i = 0; i < TableDepth; i++) begin
      if (eq_w[i]) begin
        res.any_eq      = 1'b1;
        res.match_count = res.match_count | count_w[i];
      end
      if (rd_idx == IdxWidth'(i)) begin
        res.rd_key   = res.rd_key | key_w[i];
        res.rd_count = res.rd_count | count_w[i];
      end
    end
  end

endmodule

// ===== hw/rtl/sorted_color_histogram_core.sv =====
// ----------------------------------------------------------------------------
// Sorted color histogram core
// Counts distinct colors kept in ascending order in a row of 64 cells.
// ----------------------------------------------------------------------------
// One transaction per cycle is sustained while the result stream is not stalled.
// An accepted item is registered; once the output register can take its
// result, every cell compares its color with it at once and the row shifts by
// one cell to make room for an insert; that row update sets the rate.
// A result waits in the output register while the next item is taken. Writing
// the color byte count register (address 0) also empties the table and resets
// the read cursor; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "sorted_color_histogram_core_macros.svh"

module sorted_color_histogram_core
  import schist_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] color
  input  logic [1:0]   in_tuser,   // [1:0] action
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [63:0] out_color, [95:64] occurrences,
                                   // [102:96] entries_used, [103] zero
  output logic [2:0]   out_tuser,  // [0] is_new, [1] dropped, [2] empty_res
  output logic         out_tlast,  // last_entry
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [BppWidth-1:0]   bpp_r;
  logic [UsedWidth-1:0]  used_r,   used_nxt;
  logic [IdxWidth-1:0]   cursor_r, cursor_nxt;

  logic                  item_valid_r;
  action_t               item_action_r;
  logic [ColorWidth-1:0] item_color_r;

  logic                  out_tvalid_r;
  logic [103:0]          out_tdata_r, out_tdata_nxt;
  logic [2:0]            out_tuser_r, out_tuser_nxt;
  logic                  out_tlast_r, out_tlast_nxt;

  logic                  exec_fire;
  logic                  cfg_write;
  logic [IdxWidth-1:0]   rd_idx;
  logic [UsedWidth-1:0]  rd_idx_p1;
  cell_ctrl_t            ctrl;
  chain_res_t            res;

  // result fields
  logic [ColorWidth-1:0] r_color;
  logic [OccWidth-1:0]   r_occ;
  logic                  r_new, r_drop, r_last, r_empty;

  assign exec_fire  = item_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready  = !item_valid_r || exec_fire;
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {{(32-BppWidth){1'b0}}, bpp_r} : 32'd0;

  // stale cursor restarts at the first entry
  assign rd_idx    = ({1'b0, cursor_r} >= used_r) ? '0 : cursor_r;
  assign rd_idx_p1 = {1'b0, rd_idx} + UsedWidth'(1);

  schist_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .color  (item_color_r),
    .used   (used_r),
    .rd_idx (rd_idx),
    .res    (res)
  );

  always_comb begin
    used_nxt   = used_r;
    cursor_nxt = cursor_r;
    ctrl       = '0;
    r_color    = '0;
    r_occ      = '0;
    r_new      = 1'b0;
    r_drop     = 1'b0;
    r_last     = 1'b0;
    r_empty    = 1'b0;
    unique case (item_action_r)
      ACT_COUNT: begin
        r_color       = item_color_r;
        ctrl.count_en = exec_fire;
        if (res.any_eq) begin
          r_occ = (res.match_count == CountMax) ? OccWidth'(res.match_count)
                                                : OccWidth'(res.match_count + CountWidth'(1));
        end else if (used_r == UsedWidth'(TableDepth)) begin
          r_drop = 1'b1;
        end else begin
          ctrl.insert_en = exec_fire;
          r_occ          = OccWidth'(1);
          r_new          = 1'b1;
          used_nxt       = used_r + UsedWidth'(1);
        end
      end
      ACT_READ: begin
        if (used_r == '0) begin
          r_empty = 1'b1;
        end else begin
          r_color    = res.rd_key;
          r_occ      = OccWidth'(res.rd_count);
          r_last     = (rd_idx_p1 == used_r);
          cursor_nxt = (rd_idx_p1 >= used_r) ? '0 : rd_idx_p1[IdxWidth-1:0];
        end
      end
      ACT_CLEAR: begin
        used_nxt   = '0;
        cursor_nxt = '0;
      end
      default: ;
    endcase
    out_tdata_nxt = {1'b0, used_nxt, r_occ, r_color};
    out_tuser_nxt = {r_empty, r_drop, r_new};
    out_tlast_nxt = r_last;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= BppReset;
      used_r       <= '0;
      cursor_r     <= '0;
      item_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        bpp_r    <= cfg_pwdata[BppWidth-1:0];
        used_r   <= '0;
        cursor_r <= '0;
      end else if (exec_fire) begin
        used_r   <= used_nxt;
        cursor_r <= cursor_nxt;
      end
      if (in_tvalid && in_tready) begin
        item_valid_r <= 1'b1;
      end else if (exec_fire) begin
        item_valid_r <= 1'b0;
      end
      if (exec_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_action_r <= action_t'(in_tuser);
      item_color_r  <= in_tdata & color_mask(bpp_r);
    end
    if (exec_fire) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
      out_tlast_r <= out_tlast_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `SCH_ASSERT_ALWAYS(a_used_bound, clk, rst_n, used_r <= UsedWidth'(TableDepth), "entry count beyond table depth")
  `SCH_ASSERT_ALWAYS(a_cursor_in_range, clk, rst_n, (cursor_r == '0) || ({1'b0, cursor_r} < used_r), "read cursor past stored entries")
  `SCH_ASSERT_NEXT(a_clear_empties, clk, rst_n, exec_fire && (item_action_r == ACT_CLEAR), used_r == '0, "clear left entries behind")
  `SCH_ASSERT_ALWAYS(a_new_or_drop, clk, rst_n, !(out_tvalid_r && out_tuser_r[0] && out_tuser_r[1]), "result both inserted and dropped")

endmodule
